>>> hdl/bpfa_pkg.sv
// shared constants, codes and types of the page frame allocator
package bpfa_pkg;

   localparam int NUM_FRAMES  = 1048576;
   localparam int MAX_REGIONS = 64;
   localparam int MAP_WORDS   = (NUM_FRAMES + 31) / 32;
   localparam int WORD_AW     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int REG_AW      = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
   localparam int RCW         = $clog2(MAX_REGIONS + 1);
   localparam int FCW         = 22;
   localparam int WCW         = FCW - 5;
   localparam int REGION_W    = 66;
   localparam int REQ_DW      = 200;
   localparam int RSP_DW      = 40;

   localparam logic [FCW-1:0] NUM_F      = FCW'(NUM_FRAMES);
   localparam logic [20:0]    LIMIT_CAP  = 21'(NUM_FRAMES & ~7);
   localparam logic [RCW-1:0] MAX_R      = RCW'(MAX_REGIONS);
   localparam logic [63:0]    LOW_MEM    = 64'h0000_0000_0010_0000;
   localparam logic [63:0]    ADDR_TOP   = 64'h0000_0001_0000_0000;
   localparam logic [32:0]    ADDR_TOP33 = 33'h1_0000_0000;

   typedef enum logic [1:0] {
      ACT_ENTRY, ACT_FINISH, ACT_ALLOC, ACT_FREE
   } action_type;

   typedef enum logic [2:0] {
      ST_OK, ST_UNALIGNED, ST_RESERVED, ST_NOT_USABLE, ST_DOUBLE_FREE, ST_NO_MEMORY,
      ST_IGNORED
   } status_type;

   typedef enum logic [1:0] {
      CSR_KSTART, CSR_KEND, CSR_KPAGES, CSR_BOOTDIR
   } csr_type;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_ENTRY_SUM, S_ENTRY_APPLY, S_FILL_RD, S_FILL_WR, S_FIN_NEXT,
      S_ALLOC_RD, S_ALLOC_CHK, S_FREE_PRE, S_SCAN_RD, S_SCAN_CHK, S_FREE_RD, S_FREE_CHK,
      S_RESP
   } state_type;

   typedef struct packed {
      logic capture;
      logic clr_step;
      logic entry_sum;
      logic entry_apply;
      logic fin_load;
      logic fin_done;
      logic fill_rd;
      logic fill_wr;
      logic alloc_rd;
      logic alloc_chk;
      logic free_pre;
      logic scan_rd;
      logic scan_chk;
      logic free_rd;
      logic free_chk;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic store;
      logic fill_done;
      logic fill_fin;
      logic fin_more;
      logic alloc_over;
      logic alloc_hit;
      logic pre_fail;
      logic scan_hit;
      logic scan_last;
      logic clr_last;
      logic slot_free;
   } stat_type;

endpackage

>>> hdl/bitmap_page_frame_allocator.sv
// top level of the bitmap page frame allocator
//
//  channel  direction  handshake              payload
//  req      in         req_tvalid/req_tready  req_tdata, req_tuser (action)
//  rsp      out        rsp_tvalid/rsp_tready  rsp_tdata
//  csr      in         csr_wr_en              csr_index, csr_wr_data
//
// map entry: a stored entry frees its frames in the bitmap word by word
// finish: marks the reserved frames word by word; allocate: scans bitmap words for a free bit
// free: checks the regions in turn, then a read-modify-write of the bitmap word
// after reset a clearing pass sets every bitmap word, req_tready low
// one word is accepted at a time; a finished result waits in the output register
module bitmap_page_frame_allocator (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // entry_base, entry_length, entry_kind, release_addr, in_bootstrap, zero pad
   input  logic [bpfa_pkg::REQ_DW-1:0] req_tdata,
   // action
   input  logic [1:0]                  req_tuser,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // frame_addr, ok, status, zero pad
   output logic [bpfa_pkg::RSP_DW-1:0] rsp_tdata,
   input  logic                        csr_wr_en,
   input  logic [1:0]                  csr_index,
   input  logic [31:0]                 csr_wr_data
);

   bpfa_pkg::cmd_type  cmd;
   bpfa_pkg::stat_type stat;

   bpfa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .stat       (stat),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   bpfa_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

>>> hdl/bpfa_ram.sv
// generic single write port ram with registered read
module bpfa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/bpfa_ctrl.sv
// sequencing state machine of the page frame allocator
module bpfa_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   input  logic [1:0]         req_tuser,
   input  bpfa_pkg::stat_type stat,
   output logic               req_tready,
   output bpfa_pkg::cmd_type  cmd
);

   bpfa_pkg::state_type state_ff, state_in;
   logic                accept;

   assign req_tready = (state_ff == bpfa_pkg::S_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bpfa_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bpfa_pkg::S_CLEAR: begin
            if (stat.clr_last) state_in = bpfa_pkg::S_IDLE;
         end
         bpfa_pkg::S_IDLE: begin
            if (accept) begin
               unique case (bpfa_pkg::action_type'(req_tuser))
                  bpfa_pkg::ACT_ENTRY:  state_in = bpfa_pkg::S_ENTRY_SUM;
                  bpfa_pkg::ACT_FINISH: state_in = bpfa_pkg::S_FIN_NEXT;
                  bpfa_pkg::ACT_ALLOC:  state_in = bpfa_pkg::S_ALLOC_RD;
                  bpfa_pkg::ACT_FREE:   state_in = bpfa_pkg::S_FREE_PRE;
               endcase
            end
         end
         bpfa_pkg::S_ENTRY_SUM: begin
            state_in = stat.full ? bpfa_pkg::S_RESP : bpfa_pkg::S_ENTRY_APPLY;
         end
         bpfa_pkg::S_ENTRY_APPLY: begin
            state_in = stat.store ? bpfa_pkg::S_FILL_RD : bpfa_pkg::S_RESP;
         end
         bpfa_pkg::S_FILL_RD: begin
            if (stat.fill_done) begin
               state_in = stat.fill_fin ? bpfa_pkg::S_FIN_NEXT : bpfa_pkg::S_RESP;
            end else begin
               state_in = bpfa_pkg::S_FILL_WR;
            end
         end
         bpfa_pkg::S_FILL_WR:  state_in = bpfa_pkg::S_FILL_RD;
         bpfa_pkg::S_FIN_NEXT: begin
            state_in = stat.fin_more ? bpfa_pkg::S_FILL_RD : bpfa_pkg::S_RESP;
         end
         bpfa_pkg::S_ALLOC_RD: begin
            state_in = stat.alloc_over ? bpfa_pkg::S_RESP : bpfa_pkg::S_ALLOC_CHK;
         end
         bpfa_pkg::S_ALLOC_CHK: begin
            state_in = stat.alloc_hit ? bpfa_pkg::S_RESP : bpfa_pkg::S_ALLOC_RD;
         end
         bpfa_pkg::S_FREE_PRE: begin
            state_in = stat.pre_fail ? bpfa_pkg::S_RESP : bpfa_pkg::S_SCAN_RD;
         end
         bpfa_pkg::S_SCAN_RD: state_in = bpfa_pkg::S_SCAN_CHK;
         bpfa_pkg::S_SCAN_CHK: begin
            if (stat.scan_hit) begin
               state_in = bpfa_pkg::S_FREE_RD;
            end else if (stat.scan_last) begin
               state_in = bpfa_pkg::S_RESP;
            end else begin
               state_in = bpfa_pkg::S_SCAN_RD;
            end
         end
         bpfa_pkg::S_FREE_RD:  state_in = bpfa_pkg::S_FREE_CHK;
         bpfa_pkg::S_FREE_CHK: state_in = bpfa_pkg::S_RESP;
         bpfa_pkg::S_RESP: begin
            if (stat.slot_free) state_in = bpfa_pkg::S_IDLE;
         end
         default: state_in = bpfa_pkg::S_CLEAR;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         bpfa_pkg::S_CLEAR:       cmd.clr_step = 1'b1;
         bpfa_pkg::S_IDLE:        cmd.capture = accept;
         bpfa_pkg::S_ENTRY_SUM:   cmd.entry_sum = 1'b1;
         bpfa_pkg::S_ENTRY_APPLY: cmd.entry_apply = 1'b1;
         bpfa_pkg::S_FILL_RD:     cmd.fill_rd = !stat.fill_done;
         bpfa_pkg::S_FILL_WR:     cmd.fill_wr = 1'b1;
         bpfa_pkg::S_FIN_NEXT: begin
            cmd.fin_load = stat.fin_more;
            cmd.fin_done = !stat.fin_more;
         end
         bpfa_pkg::S_ALLOC_RD:    cmd.alloc_rd = !stat.alloc_over;
         bpfa_pkg::S_ALLOC_CHK:   cmd.alloc_chk = 1'b1;
         bpfa_pkg::S_FREE_PRE:    cmd.free_pre = 1'b1;
         bpfa_pkg::S_SCAN_RD:     cmd.scan_rd = 1'b1;
         bpfa_pkg::S_SCAN_CHK:    cmd.scan_chk = 1'b1;
         bpfa_pkg::S_FREE_RD:     cmd.free_rd = 1'b1;
         bpfa_pkg::S_FREE_CHK:    cmd.free_chk = 1'b1;
         bpfa_pkg::S_RESP:        cmd.rsp_load = stat.slot_free;
         default:                 cmd = '0;
      endcase
   end

endmodule

>>> hdl/bpfa_dp.sv
// datapath: registers, frame bitmap, region store and result register
module bpfa_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  bpfa_pkg::cmd_type             cmd,
   output bpfa_pkg::stat_type            stat,
   input  logic [bpfa_pkg::REQ_DW-1:0]   req_tdata,
   input  logic [1:0]                    req_tuser,
   input  logic                          csr_wr_en,
   input  logic [1:0]                    csr_index,
   input  logic [31:0]                   csr_wr_data,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [bpfa_pkg::RSP_DW-1:0]   rsp_tdata
);

   localparam int FCW = bpfa_pkg::FCW;
   localparam int WCW = bpfa_pkg::WCW;
   localparam int WAW = bpfa_pkg::WORD_AW;
   localparam int RCW = bpfa_pkg::RCW;

   // configuration
   logic [31:0] kstart_ff, kend_ff, bootdir_ff;
   logic [10:0] kpages_ff;

   // captured word
   logic [1:0]  act_ff;
   logic [63:0] base_ff, len_ff, end_ff;
   logic [31:0] kind_ff, raddr_ff;
   logic        boot_ff;

   // allocator state
   logic [31:0]    highest_ff;
   logic [20:0]    scan_limit_ff;
   logic [RCW-1:0] region_count_ff, entry_count_ff, idx_ff;

   // working registers
   logic [FCW-1:0] cur_ff, stop_ff;
   logic           fill_val_ff;
   logic [1:0]     fin_step_ff;
   logic [WCW-1:0] word_ff;
   logic [WAW-1:0] clr_ff;

   // result
   logic [31:0]                 res_addr_ff;
   logic                        res_ok_ff;
   bpfa_pkg::status_type        res_st_ff;
   logic                        rsp_valid_ff;
   logic [bpfa_pkg::RSP_DW-1:0] rsp_data_ff;

   // memories
   logic                           bm_wr_en;
   logic [WAW-1:0]                 bm_wr_addr, bm_rd_addr;
   logic [31:0]                    bm_wr_data, bm_rd;
   logic                           rg_wr_en;
   logic [bpfa_pkg::REGION_W-1:0]  rg_rd;

   // combinational terms
   logic [64:0]    sum65;
   logic [32:0]    s33, e33;
   logic [33:0]    s_up;
   logic [32:0]    kend_up;
   logic [FCW-1:0] khi;
   logic [FCW-1:0] ld_first, ld_raw, ld_stop;
   logic           ld_en;
   logic [FCW-1:0] cur_word, stop_word;
   logic [31:0]    fill_mask;
   logic [FCW-1:0] wbase, left;
   logic [31:0]    avail, lowest;
   logic [4:0]     bit_sel;
   logic [19:0]    fr;
   logic [FCW-1:0] fr_word;
   logic           unaligned, reserved, out_range;
   logic [32:0]    rg_start, rg_top;
   logic           fr_used;
   logic [19:0]    lim;

   assign sum65    = {1'b0, base_ff} + {1'b0, len_ff};
   assign s33      = (base_ff > bpfa_pkg::ADDR_TOP) ? bpfa_pkg::ADDR_TOP33 : base_ff[32:0];
   assign e33      = (end_ff > bpfa_pkg::ADDR_TOP) ? bpfa_pkg::ADDR_TOP33 : end_ff[32:0];
   assign s_up     = {1'b0, s33} + 34'd4095;
   assign kend_up  = {1'b0, kend_ff} + 33'd4095;
   assign khi      = {1'b0, kend_up[32:12]} + FCW'(kpages_ff);

   assign stat.full  = (entry_count_ff >= bpfa_pkg::MAX_R);
   assign stat.store = (kind_ff == 32'd1) && (base_ff >= bpfa_pkg::LOW_MEM) &&
                       (region_count_ff < bpfa_pkg::MAX_R);

   // range loads for map entries and finish steps
   always_comb begin
      ld_en    = 1'b0;
      ld_first = '0;
      ld_raw   = '0;
      if (cmd.entry_apply) begin
         ld_en    = stat.store;
         ld_first = s_up[33:12];
         ld_raw   = {1'b0, e33[32:12]};
      end else if (cmd.fin_load) begin
         ld_en = 1'b1;
         case (fin_step_ff)
            2'd0: begin
               ld_first = '0;
               ld_raw   = FCW'(1);
            end
            2'd1: begin
               ld_first = {2'b0, bootdir_ff[31:12]};
               ld_raw   = {2'b0, bootdir_ff[31:12]} + FCW'(1);
            end
            2'd2: begin
               ld_first = {2'b0, kstart_ff[31:12]};
               ld_raw   = khi;
            end
            default: begin
               ld_first = '0;
               ld_raw   = '0;
            end
         endcase
      end
      ld_stop = (ld_raw > bpfa_pkg::NUM_F) ? bpfa_pkg::NUM_F : ld_raw;
   end

   assign cur_word       = cur_ff >> 5;
   assign stop_word      = stop_ff >> 5;
   assign stat.fill_done = (cur_ff >= stop_ff);
   assign stat.fill_fin  = (act_ff == bpfa_pkg::ACT_FINISH);
   assign stat.fin_more  = (fin_step_ff != 2'd3);
   assign fill_mask = ({32{1'b1}} << cur_ff[4:0]) &
                      ((stop_word == cur_word) ? ((32'd1 << stop_ff[4:0]) - 32'd1)
                                               : {32{1'b1}});

   // allocation word check
   assign wbase           = {word_ff, 5'b0};
   assign left            = {1'b0, scan_limit_ff} - wbase;
   assign stat.alloc_over = (wbase >= {1'b0, scan_limit_ff});
   assign avail  = ~bm_rd & ((left[FCW-1:5] == '0) ? ((32'd1 << left[4:0]) - 32'd1)
                                                   : {32{1'b1}});
   assign lowest = avail & (~avail + 32'd1);
   assign stat.alloc_hit = (avail != 32'd0);

   always_comb begin
      bit_sel = '0;
      for (int i = 0; i < 32; i++) begin
         if (lowest[i]) bit_sel = bit_sel | 5'(i);
      end
   end

   // free checks
   assign fr        = raddr_ff[31:12];
   assign fr_word   = {2'b0, fr} >> 5;
   assign unaligned = (raddr_ff[11:0] != 12'd0);
   assign reserved  = (boot_ff && (raddr_ff == bootdir_ff)) || (raddr_ff >= highest_ff) ||
                      (({2'b0, fr} >= {2'b0, kstart_ff[31:12]}) && ({2'b0, fr} < khi));
   assign out_range = ({2'b0, fr} >= bpfa_pkg::NUM_F);
   assign stat.pre_fail = unaligned || reserved || out_range || (region_count_ff == '0);
   assign rg_start  = rg_rd[65:33];
   assign rg_top    = {rg_rd[32:12], 12'b0};
   assign stat.scan_hit  = ({1'b0, raddr_ff} >= rg_start) && ({1'b0, raddr_ff} < rg_top);
   assign stat.scan_last = ((idx_ff + RCW'(1)) >= region_count_ff);
   assign fr_used   = bm_rd[fr[4:0]];

   assign stat.clr_last  = (clr_ff == WAW'(bpfa_pkg::MAP_WORDS - 1));
   assign stat.slot_free = !rsp_valid_ff || rsp_tready;

   assign lim = {highest_ff[31:15], 3'b0};

   // bitmap ports
   always_comb begin
      bm_wr_en   = 1'b0;
      bm_wr_addr = cur_word[WAW-1:0];
      bm_wr_data = bm_rd | fill_mask;
      if (cmd.clr_step) begin
         bm_wr_en   = 1'b1;
         bm_wr_addr = clr_ff;
         bm_wr_data = {32{1'b1}};
      end else if (cmd.fill_wr) begin
         bm_wr_en   = 1'b1;
         bm_wr_data = fill_val_ff ? (bm_rd | fill_mask) : (bm_rd & ~fill_mask);
      end else if (cmd.alloc_chk) begin
         bm_wr_en   = stat.alloc_hit;
         bm_wr_addr = word_ff[WAW-1:0];
         bm_wr_data = bm_rd | lowest;
      end else if (cmd.free_chk) begin
         bm_wr_en   = fr_used;
         bm_wr_addr = fr_word[WAW-1:0];
         bm_wr_data = bm_rd & ~(32'd1 << fr[4:0]);
      end
   end

   always_comb begin
      if (cmd.alloc_rd) begin
         bm_rd_addr = word_ff[WAW-1:0];
      end else if (cmd.free_rd) begin
         bm_rd_addr = fr_word[WAW-1:0];
      end else begin
         bm_rd_addr = cur_word[WAW-1:0];
      end
   end

   assign rg_wr_en = cmd.entry_apply && stat.store;

   bpfa_ram #(
      .WIDTH (32),
      .DEPTH (bpfa_pkg::MAP_WORDS)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (bm_wr_en),
      .wr_addr (bm_wr_addr),
      .wr_data (bm_wr_data),
      .rd_addr (bm_rd_addr),
      .rd_data (bm_rd)
   );

   bpfa_ram #(
      .WIDTH (bpfa_pkg::REGION_W),
      .DEPTH (bpfa_pkg::MAX_REGIONS)
   ) u_regions (
      .clock   (clock),
      .wr_en   (rg_wr_en),
      .wr_addr (region_count_ff[bpfa_pkg::REG_AW-1:0]),
      .wr_data ({s33, e33}),
      .rd_addr (idx_ff[bpfa_pkg::REG_AW-1:0]),
      .rd_data (rg_rd)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         kstart_ff       <= 32'h0010_0000;
         kend_ff         <= 32'h0010_0000;
         kpages_ff       <= 11'd1;
         bootdir_ff      <= 32'h0000_1000;
         highest_ff      <= '0;
         scan_limit_ff   <= '0;
         region_count_ff <= '0;
         entry_count_ff  <= '0;
         clr_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (bpfa_pkg::csr_type'(csr_index))
               bpfa_pkg::CSR_KSTART:  kstart_ff  <= csr_wr_data;
               bpfa_pkg::CSR_KEND:    kend_ff    <= csr_wr_data;
               bpfa_pkg::CSR_KPAGES:  kpages_ff  <= csr_wr_data[10:0];
               bpfa_pkg::CSR_BOOTDIR: bootdir_ff <= csr_wr_data;
            endcase
         end
         if (cmd.clr_step) clr_ff <= clr_ff + WAW'(1);
         if (cmd.entry_apply) begin
            entry_count_ff <= entry_count_ff + RCW'(1);
            if (end_ff > {32'b0, highest_ff}) begin
               highest_ff <= (end_ff[63:32] != 32'd0) ? 32'hFFFF_FFFF : end_ff[31:0];
            end
            if (stat.store) region_count_ff <= region_count_ff + RCW'(1);
         end
         if (cmd.fin_done) begin
            scan_limit_ff <= ({1'b0, lim} > bpfa_pkg::LIMIT_CAP) ? bpfa_pkg::LIMIT_CAP
                                                                 : {1'b0, lim};
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff      <= req_tuser;
         base_ff     <= req_tdata[63:0];
         len_ff      <= req_tdata[127:64];
         kind_ff     <= req_tdata[159:128];
         raddr_ff    <= req_tdata[191:160];
         boot_ff     <= req_tdata[192];
         res_addr_ff <= '0;
         res_ok_ff   <= 1'b0;
         res_st_ff   <= (req_tuser == bpfa_pkg::ACT_ALLOC) ? bpfa_pkg::ST_NO_MEMORY
                                                           : bpfa_pkg::ST_OK;
         word_ff     <= '0;
         idx_ff      <= '0;
         fin_step_ff <= '0;
      end
      if (cmd.entry_sum) begin
         end_ff <= sum65[64] ? {64{1'b1}} : sum65[63:0];
         if (stat.full) res_st_ff <= bpfa_pkg::ST_IGNORED;
      end
      if (ld_en) begin
         cur_ff      <= ld_first;
         stop_ff     <= ld_stop;
         fill_val_ff <= cmd.fin_load;
      end
      if (cmd.entry_apply && stat.store) res_ok_ff <= 1'b1;
      if (cmd.fin_load) fin_step_ff <= fin_step_ff + 2'd1;
      if (cmd.fin_done) res_ok_ff <= 1'b1;
      if (cmd.fill_wr) cur_ff <= (cur_ff | FCW'(31)) + FCW'(1);
      if (cmd.alloc_chk) begin
         if (stat.alloc_hit) begin
            res_addr_ff <= {wbase[19:5], bit_sel, 12'b0};
            res_ok_ff   <= 1'b1;
            res_st_ff   <= bpfa_pkg::ST_OK;
         end else begin
            word_ff <= word_ff + WCW'(1);
         end
      end
      if (cmd.free_pre) begin
         if (unaligned) begin
            res_st_ff <= bpfa_pkg::ST_UNALIGNED;
         end else if (reserved) begin
            res_st_ff <= bpfa_pkg::ST_RESERVED;
         end else if (stat.pre_fail) begin
            res_st_ff <= bpfa_pkg::ST_NOT_USABLE;
         end
      end
      if (cmd.scan_chk && !stat.scan_hit) begin
         idx_ff <= idx_ff + RCW'(1);
         if (stat.scan_last) res_st_ff <= bpfa_pkg::ST_NOT_USABLE;
      end
      if (cmd.free_chk) begin
         if (fr_used) begin
            res_ok_ff <= 1'b1;
         end else begin
            res_st_ff <= bpfa_pkg::ST_DOUBLE_FREE;
         end
      end
      if (cmd.rsp_load) rsp_data_ff <= {4'b0, res_st_ff, res_ok_ff, res_addr_ff};
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> hdl/bpfa_checker.sv
// port checker of the page frame allocator and its bind
module bpfa_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_tready,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [bpfa_pkg::RSP_DW-1:0] rsp_tdata
);

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp word changed while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[32] |-> rsp_tdata[35:33] == bpfa_pkg::ST_OK)
      else $error("ok with nonzero status");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[11:0] == 12'd0 && (rsp_tdata[31:0] == 32'd0 || rsp_tdata[32]))
      else $error("bad frame address");

   assert property (@(posedge clock)
      $past(reset) |-> !req_tready)
      else $error("ready during bitmap clear");

endmodule

bind bitmap_page_frame_allocator bpfa_checker u_bpfa_checker (.*);
